>>> hdl/rrte_pkg.sv
// Shared types and constants for the RIP route table engine.
package rrte_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [4:0] METRIC_INF = 5'd16;
  localparam logic [1:0] IFACE_NONE = 2'd2;
  localparam logic [2:0] AGE_MAX    = 3'd7;

  localparam logic [1:0] OP_LEARN  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_ADVERT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [3:0] ST_IGNORED   = 4'd0;
  localparam logic [3:0] ST_UNCHANGED = 4'd1;
  localparam logic [3:0] ST_REVIVED   = 4'd2;
  localparam logic [3:0] ST_IMPROVED  = 4'd3;
  localparam logic [3:0] ST_INSERTED  = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_TICK_DONE = 4'd6;
  localparam logic [3:0] ST_ADV_ENTRY = 4'd7;
  localparam logic [3:0] ST_ADV_EMPTY = 4'd8;

  localparam logic [2:0] REG_IFACE0_ADDR = 3'd0;
  localparam logic [2:0] REG_IFACE0_MASK = 3'd1;
  localparam logic [2:0] REG_IFACE1_ADDR = 3'd2;
  localparam logic [2:0] REG_IFACE1_MASK = 3'd3;
  localparam logic [2:0] REG_TIMEOUT     = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] dest_addr;
    logic [31:0] dest_mask;
    logic [31:0] sender_addr;
    logic [31:0] recv_metric;
    logic        iface_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] route_next_hop;
    logic [4:0]  route_metric;
    logic [1:0]  route_iface;
    logic        last_item;
  } out_item_t;

  typedef struct packed {
    logic [1:0][31:0] addr;
    logic [1:0][31:0] mask;
    logic [2:0]       timeout;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_IGNORE,
    CMD_LEARN,
    CMD_TICK,
    CMD_ADV,
    CMD_ADV_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] sender;
    logic [4:0]  hops;
    logic [1:0]  iface;
    logic [31:0] sel_addr;
    logic [31:0] sel_mask;
    logic [2:0]  timeout;
  } cmd_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic [4:0]  metric;
    logic [1:0]  iface;
  } entry_t;

endpackage

>>> hdl/rrte_front.sv
// Front end: accepts requests and turns them into table commands.
module rrte_front #(
  parameter int NUM_IFACES = 2
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  rrte_pkg::in_item_t in_data,
  input  rrte_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output rrte_pkg::cmd_t    q_data
);
  import rrte_pkg::*;

  logic [32:0] dist33;
  logic        ignored;
  logic [1:0]  ifc;
  logic        sel_bad;
  logic        has_cmd;

  assign in_stall = q_full;
  assign dist33   = {1'b0, in_data.recv_metric} + 33'd1;
  assign ignored  = dist33 >= 33'd16;
  assign sel_bad  = 32'(in_data.iface_select) >= 32'(NUM_IFACES);

  always_comb begin
    ifc = IFACE_NONE;
    for (int i = 1; i >= 0; i--) begin
      if (i < NUM_IFACES &&
          (in_data.sender_addr & in_data.dest_mask) == (cfg.addr[i] & in_data.dest_mask)) begin
        ifc = 2'(i);
      end
    end
  end

  always_comb begin
    has_cmd         = 1'b1;
    q_data.kind     = CMD_TICK;
    q_data.prefix   = in_data.dest_addr & in_data.dest_mask;
    q_data.mask     = in_data.dest_mask;
    q_data.sender   = in_data.sender_addr;
    q_data.hops     = dist33[4:0];
    q_data.iface    = ifc;
    q_data.sel_addr = cfg.addr[in_data.iface_select];
    q_data.sel_mask = cfg.mask[in_data.iface_select];
    q_data.timeout  = cfg.timeout;
    case (in_data.operation)
      OP_LEARN:  q_data.kind = ignored ? CMD_IGNORE : CMD_LEARN;
      OP_TICK:   q_data.kind = CMD_TICK;
      OP_ADVERT: q_data.kind = sel_bad ? CMD_ADV_EMPTY : CMD_ADV;
      default:   has_cmd = 1'b0;
    endcase
  end

  // unknown operations are taken and dropped here
  assign q_push = in_valid && !q_full && has_cmd;

endmodule

>>> hdl/rrte_cmd_queue.sv
// Short command queue between front and back ends.
module rrte_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rrte_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rrte_pkg::cmd_t pop_data
);
  import rrte_pkg::*;

  cmd_t                slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full     = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

endmodule

>>> hdl/rrte_back.sv
// Back end: route table storage, slot walk and result register.
module rrte_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rrte_pkg::cmd_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rrte_pkg::out_item_t out_data
);
  import rrte_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic   rd_en, we;
  logic [IW-1:0] wa;
  entry_t wd;

  state_t    state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic      pv_r, pv_nxt;
  logic [IW-1:0] eidx_r, eidx_nxt;
  logic      free_v_r, free_v_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic      pend_v_r, pend_v_nxt;
  entry_t    pend_r, pend_nxt;
  logic [RES_W-1:0] n_r, n_nxt;
  out_item_t res_r, res_nxt;
  logic      out_v_r, out_v_nxt;
  out_item_t out_r, out_nxt;
  logic [TABLE_DEPTH-1:0] used_r, used_nxt, live_r, live_nxt;
  logic [2:0] age_r [TABLE_DEPTH];
  logic [2:0] age_nxt [TABLE_DEPTH];

  logic   free_o, adv, done, qual, hit;
  entry_t upd;
  logic [2:0] a;

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign free_o    = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q <= mem[cnt_r[IW-1:0]];
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = pv_r;
    eidx_nxt     = eidx_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    out_v_nxt    = out_v_r && out_stall;
    out_nxt      = out_r;
    used_nxt     = used_r;
    live_nxt     = live_r;
    age_nxt      = age_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    we           = 1'b0;
    wa           = eidx_r;
    wd           = rd_q;
    adv          = 1'b1;
    done         = !pv_r && cnt_r == CW'(TABLE_DEPTH);
    hit          = used_r[eidx_r] && ((rd_q.prefix & cmd_r.mask) == cmd_r.prefix);
    qual         = used_r[eidx_r] && live_r[eidx_r] &&
                   ((rd_q.next_hop & cmd_r.sel_mask) != (cmd_r.sel_addr & cmd_r.sel_mask)) &&
                   n_r < RES_W'(MAX_RESULTS);
    upd          = rd_q;
    upd.next_hop = cmd_r.sender;
    upd.metric   = cmd_r.hops;
    upd.iface    = cmd_r.iface;
    a            = '0;

    case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          cmd_nxt    = q_data;
          cnt_nxt    = '0;
          pv_nxt     = 1'b0;
          free_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          n_nxt      = '0;
          state_nxt  = S_EMIT;
          case (q_data.kind)
            CMD_IGNORE: res_nxt = '{ST_IGNORED, q_data.prefix, q_data.mask, q_data.sender,
                                    METRIC_INF, IFACE_NONE, 1'b1};
            CMD_TICK: begin
              for (int s = 0; s < TABLE_DEPTH; s++) begin
                if (used_r[s] && live_r[s]) begin
                  a = (age_r[s] == AGE_MAX) ? AGE_MAX : age_r[s] + 3'd1;
                  age_nxt[s] = a;
                  if (a > q_data.timeout || a == AGE_MAX) live_nxt[s] = 1'b0;
                end
              end
              res_nxt = '{ST_TICK_DONE, 32'd0, 32'd0, 32'd0, 5'd0, IFACE_NONE, 1'b1};
            end
            CMD_ADV_EMPTY: res_nxt = '{ST_ADV_EMPTY, 32'd0, 32'd0, 32'd0, 5'd0,
                                       IFACE_NONE, 1'b1};
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_EMIT: begin
        if (free_o) begin
          out_v_nxt = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (done) begin
          state_nxt = S_EMIT;
          if (cmd_r.kind == CMD_LEARN) begin
            if (free_v_r) begin
              we  = 1'b1;
              wa  = free_idx_r;
              wd  = '{cmd_r.prefix, cmd_r.mask, cmd_r.sender, cmd_r.hops, cmd_r.iface};
              used_nxt[free_idx_r] = 1'b1;
              live_nxt[free_idx_r] = 1'b1;
              age_nxt[free_idx_r]  = '0;
              res_nxt = '{ST_INSERTED, cmd_r.prefix, cmd_r.mask, cmd_r.sender, cmd_r.hops,
                          cmd_r.iface, 1'b1};
            end else begin
              res_nxt = '{ST_FULL, cmd_r.prefix, cmd_r.mask, cmd_r.sender, cmd_r.hops,
                          cmd_r.iface, 1'b1};
            end
          end else if (pend_v_r) begin
            res_nxt = '{ST_ADV_ENTRY, pend_r.prefix, pend_r.mask, pend_r.next_hop,
                        pend_r.metric, pend_r.iface, 1'b1};
          end else begin
            res_nxt = '{ST_ADV_EMPTY, 32'd0, 32'd0, 32'd0, 5'd0, IFACE_NONE, 1'b1};
          end
        end else begin
          if (pv_r) begin
            if (cmd_r.kind == CMD_LEARN) begin
              if (hit) begin
                adv       = 1'b0;
                state_nxt = S_EMIT;
                if (!live_r[eidx_r]) begin
                  we = 1'b1;
                  wd = upd;
                  live_nxt[eidx_r] = 1'b1;
                  age_nxt[eidx_r]  = '0;
                  res_nxt = '{ST_REVIVED, upd.prefix, upd.mask, upd.next_hop, upd.metric,
                              upd.iface, 1'b1};
                end else if (cmd_r.hops < rd_q.metric) begin
                  we = 1'b1;
                  wd = upd;
                  age_nxt[eidx_r] = '0;
                  res_nxt = '{ST_IMPROVED, upd.prefix, upd.mask, upd.next_hop, upd.metric,
                              upd.iface, 1'b1};
                end else begin
                  res_nxt = '{ST_UNCHANGED, rd_q.prefix, rd_q.mask, rd_q.next_hop,
                              rd_q.metric, rd_q.iface, 1'b1};
                end
              end else if (!used_r[eidx_r] && !free_v_r) begin
                free_v_nxt   = 1'b1;
                free_idx_nxt = eidx_r;
              end
            end else if (qual) begin
              // hold one entry back so the final one can carry last_item
              if (pend_v_r) begin
                if (free_o) begin
                  out_v_nxt = 1'b1;
                  out_nxt   = '{ST_ADV_ENTRY, pend_r.prefix, pend_r.mask, pend_r.next_hop,
                                pend_r.metric, pend_r.iface, 1'b0};
                  pend_nxt  = rd_q;
                  n_nxt     = n_r + 1'b1;
                end else begin
                  adv = 1'b0;
                end
              end else begin
                pend_v_nxt = 1'b1;
                pend_nxt   = rd_q;
                n_nxt      = n_r + 1'b1;
              end
            end
          end
          if (adv) begin
            pv_nxt = cnt_r != CW'(TABLE_DEPTH);
            if (cnt_r != CW'(TABLE_DEPTH)) begin
              rd_en    = 1'b1;
              eidx_nxt = cnt_r[IW-1:0];
              cnt_nxt  = cnt_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      free_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
      out_v_r  <= 1'b0;
      used_r   <= '0;
      live_r   <= '0;
      for (int s = 0; s < TABLE_DEPTH; s++) age_r[s] <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pv_r     <= pv_nxt;
      free_v_r <= free_v_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      out_v_r  <= out_v_nxt;
      used_r   <= used_nxt;
      live_r   <= live_nxt;
      age_r    <= age_nxt;
    end
    cmd_r      <= cmd_nxt;
    eidx_r     <= eidx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

>>> hdl/rip_route_table_engine_top.sv
// Top level of the RIP route table engine: config registers and wiring.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_stall  | in_data (in_item_t)
//  out_    | result    | out_valid/out_stall| out_data (out_item_t)
//  cfg     | APB write | psel/penable/pready| paddr, pwdata, prdata
//
// Learn and advertise walk the table through the one memory read port; a learn
// that hits stops the walk early, and tick and ignored learns skip it. Advertise
// pauses on out_stall per entry.
// Synchronous active-low reset clears the table flags; no clearing pass.
// A two-deep queue lets the front take requests while the back is busy.
module rip_route_table_engine_top #(
  parameter int TABLE_DEPTH = 32,
  parameter int NUM_IFACES  = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrte_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrte_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rrte_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_in, q_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr    <= '0;
      cfg_r.mask    <= '0;
      cfg_r.timeout <= 3'd5;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_IFACE0_ADDR: cfg_r.addr[0] <= pwdata;
        REG_IFACE0_MASK: cfg_r.mask[0] <= pwdata;
        REG_IFACE1_ADDR: cfg_r.addr[1] <= pwdata;
        REG_IFACE1_MASK: cfg_r.mask[1] <= pwdata;
        REG_TIMEOUT:     cfg_r.timeout <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_IFACE0_ADDR: prdata = cfg_r.addr[0];
      REG_IFACE0_MASK: prdata = cfg_r.mask[0];
      REG_IFACE1_ADDR: prdata = cfg_r.addr[1];
      REG_IFACE1_MASK: prdata = cfg_r.mask[1];
      REG_TIMEOUT:     prdata = {29'd0, cfg_r.timeout};
      default:         prdata = '0;
    endcase
  end

  rrte_front #(.NUM_IFACES(NUM_IFACES)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .cfg(cfg_r), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  rrte_cmd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_data(q_out)
  );

  rrte_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

>>> bench/rrte_route_checker.sv
// Route table checker: predicts results from accepted requests and compares them.
`timescale 1ns / 100ps
module rrte_route_checker
  import rrte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_count
);
  localparam int DEPTH = 32;

  logic [31:0] if_addr [2];
  logic [31:0] if_mask [2];
  logic [2:0]  timeout_r;
  logic        used [DEPTH];
  logic        live [DEPTH];
  logic [2:0]  age [DEPTH];
  entry_t      tbl [DEPTH];
  out_item_t   expected_routes [$];

  assign pending_count = expected_routes.size();

  function automatic logic [1:0] sender_iface(logic [31:0] snd, logic [31:0] msk);
    for (int i = 0; i < 2; i++)
      if ((snd & msk) == (if_addr[i] & msk)) return i[1:0];
    return IFACE_NONE;
  endfunction

  function automatic out_item_t mk(logic [3:0] st, entry_t e, logic last);
    out_item_t r;
    r.status = st; r.route_prefix = e.prefix; r.route_mask = e.mask;
    r.route_next_hop = e.next_hop; r.route_metric = e.metric;
    r.route_iface = e.iface; r.last_item = last;
    return r;
  endfunction

  task automatic predict_route_update(in_item_t q);
    logic [32:0] hops;
    logic [31:0] msk;
    entry_t e;
    int freeslot;
    freeslot = -1;
    msk = q.dest_mask;
    hops = {1'b0, q.recv_metric} + 33'd1;
    e.prefix = q.dest_addr & msk; e.mask = msk; e.next_hop = q.sender_addr;
    if (hops >= 33'd16) begin
      e.metric = METRIC_INF; e.iface = IFACE_NONE;
      expected_routes.push_back(mk(ST_IGNORED, e, 1'b1));
      return;
    end
    e.metric = hops[4:0];
    e.iface = sender_iface(q.sender_addr, msk);
    for (int s = 0; s < DEPTH; s++) begin
      if (!used[s]) begin
        if (freeslot < 0) freeslot = s;
        continue;
      end
      if ((tbl[s].prefix & msk) != (q.dest_addr & msk)) continue;
      if (!live[s]) begin
        live[s] = 1; age[s] = 0;
        tbl[s].next_hop = e.next_hop; tbl[s].metric = e.metric; tbl[s].iface = e.iface;
        expected_routes.push_back(mk(ST_REVIVED, tbl[s], 1'b1));
      end else if (e.metric < tbl[s].metric) begin
        age[s] = 0;
        tbl[s].next_hop = e.next_hop; tbl[s].metric = e.metric; tbl[s].iface = e.iface;
        expected_routes.push_back(mk(ST_IMPROVED, tbl[s], 1'b1));
      end else begin
        expected_routes.push_back(mk(ST_UNCHANGED, tbl[s], 1'b1));
      end
      return;
    end
    if (freeslot < 0) begin
      expected_routes.push_back(mk(ST_FULL, e, 1'b1));
      return;
    end
    used[freeslot] = 1; live[freeslot] = 1; age[freeslot] = 0; tbl[freeslot] = e;
    expected_routes.push_back(mk(ST_INSERTED, e, 1'b1));
  endtask

  task automatic predict_request(in_item_t q);
    entry_t z;
    int n;
    z = '0; z.iface = IFACE_NONE;
    n = 0;
    case (q.operation)
      OP_LEARN: predict_route_update(q);
      OP_TICK: begin
        for (int s = 0; s < DEPTH; s++) begin
          if (!used[s] || !live[s]) continue;
          if (age[s] < AGE_MAX) age[s]++;
          if (age[s] > timeout_r || age[s] >= AGE_MAX) live[s] = 0;
        end
        expected_routes.push_back(mk(ST_TICK_DONE, z, 1'b1));
      end
      OP_ADVERT: begin
        for (int s = 0; s < DEPTH; s++) begin
          if (!used[s] || !live[s]) continue;
          if ((tbl[s].next_hop & if_mask[q.iface_select]) ==
              (if_addr[q.iface_select] & if_mask[q.iface_select])) continue;
          expected_routes.push_back(mk(ST_ADV_ENTRY, tbl[s], 1'b0));
          n++;
        end
        if (n == 0) expected_routes.push_back(mk(ST_ADV_EMPTY, z, 1'b1));
        else expected_routes[$].last_item = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      if_addr[0] <= '0; if_addr[1] <= '0; if_mask[0] <= '0; if_mask[1] <= '0;
      timeout_r <= 3'd5;
      for (int s = 0; s < DEPTH; s++) begin
        used[s] = 0; live[s] = 0; age[s] = 0; tbl[s] = '0;
      end
      expected_routes.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        case (paddr[4:2])
          REG_IFACE0_ADDR: if_addr[0] <= pwdata;
          REG_IFACE0_MASK: if_mask[0] <= pwdata;
          REG_IFACE1_ADDR: if_addr[1] <= pwdata;
          REG_IFACE1_MASK: if_mask[1] <= pwdata;
          REG_TIMEOUT:     timeout_r <= pwdata[2:0];
          default: ;
        endcase
      if (out_valid && !out_stall) begin
        if (expected_routes.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          if (out_data !== expected_routes[0]) begin
            if (fail_count < 10)
              $display("mismatch: expected %p got %p", expected_routes[0], out_data);
            fail_count <= fail_count + 1;
          end
          void'(expected_routes.pop_front());
        end
      end
      if (in_valid && !in_stall) predict_request(in_data);
    end
  end
endmodule

>>> bench/rip_route_table_engine_top_test.sv
// Testbench top: drives requests, register writes and stalls; gives the verdict.
`timescale 1ns / 100ps
module rip_route_table_engine_top_test;
  import rrte_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count;
  int cycle_count = 0;

  rip_route_table_engine_top dut (.*);

  rrte_route_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // generous bound: ~310 requests, each up to 32 results with random stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("FAIL rip_route_table_engine_top");
      $finish;
    end
  end

  // result side stall: random wait per result, with quiet stretches
  int stall_left;
  int stall_draw;
  logic stall_quiet;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1; stall_left <= 0; stall_quiet <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 15) == 0) stall_quiet <= ~stall_quiet;
      stall_draw = stall_quiet ? 0 : $urandom_range(0, 9);
      stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
      out_stall <= stall_draw > 0;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // valid stays high between back-to-back requests
  task automatic send_request(in_item_t q, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_mask();
    int k;
    k = $urandom_range(0, 5);
    case (k)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom;
      default: return ~(32'hFFFF_FFFF >> $urandom_range(8, 28));
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t q;
    int k;
    q.operation = OP_LEARN;
    k = $urandom_range(0, 99);
    if (k < 55) q.operation = OP_LEARN;
    else if (k < 72) q.operation = OP_TICK;
    else if (k < 96) q.operation = OP_ADVERT;
    else q.operation = OP_UNUSED;
    // prefixes mostly from a small pool so learns hit existing routes
    q.dest_addr = ($urandom_range(0, 3) == 0) ? $urandom
                  : {8'd10, 8'($urandom_range(0, 20)), 16'($urandom_range(0, 3))};
    q.dest_mask = ($urandom_range(0, 3) == 0) ? pick_mask() : 32'hFFFF_0000;
    q.sender_addr = ($urandom_range(0, 2) == 0) ? $urandom
                    : {8'd192, 8'd168, 8'($urandom_range(0, 1)), 8'($urandom)};
    k = $urandom_range(0, 9);
    q.recv_metric = (k == 0) ? $urandom : (k == 1) ? 32'hFFFF_FFFF
                    : $urandom_range(0, 16);
    q.iface_select = $urandom_range(0, 1);
    return q;
  endfunction

  initial begin
    in_item_t q;
    rst_n = 0; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    reg_write(REG_IFACE0_ADDR, 32'hC0A8_0001);
    reg_write(REG_IFACE0_MASK, 32'hFFFF_FF00);
    reg_write(REG_IFACE1_ADDR, 32'hC0A8_0101);
    reg_write(REG_IFACE1_MASK, 32'hFFFF_FF00);
    reg_write(REG_TIMEOUT, 32'd1);

    // directed: empty advert, extremes, ignore, insert, improve, unchanged, revive
    q = '0; q.operation = OP_ADVERT; send_request(q, 0);
    q.iface_select = 1; send_request(q, 0);
    q = '0; q.operation = OP_LEARN; q.dest_addr = 32'hFFFF_FFFF;
    q.dest_mask = 32'hFFFF_FFFF; q.sender_addr = 32'hFFFF_FFFF;
    q.recv_metric = 32'hFFFF_FFFF; send_request(q, 1);
    q.recv_metric = 15; send_request(q, 0);
    q.recv_metric = 14; send_request(q, 0);
    q.recv_metric = 3; send_request(q, 0);
    q.recv_metric = 9; send_request(q, 2);
    q.dest_addr = 32'h0A00_0000; q.dest_mask = 32'hFF00_0000;
    q.sender_addr = 32'hC0A8_0105; q.recv_metric = 0; send_request(q, 0);
    q.dest_mask = 32'h0; q.sender_addr = 32'hC0A8_0007; send_request(q, 0);
    q = '0; q.operation = OP_ADVERT; send_request(q, 0);
    q.iface_select = 1; send_request(q, 3);
    q = '0; q.operation = OP_TICK; send_request(q, 0); send_request(q, 0);
    q = '0; q.operation = OP_LEARN; q.dest_addr = 32'h0A00_0000;
    q.dest_mask = 32'hFF00_0000; q.sender_addr = 32'h0101_0101;
    q.recv_metric = 1; send_request(q, 0);
    q = '0; q.operation = OP_UNUSED; q.dest_addr = '1; q.dest_mask = '1;
    q.sender_addr = '1; q.recv_metric = '1; q.iface_select = 1; send_request(q, 0);
    // fill the table to reach the full case
    for (int i = 0; i < 33; i++) begin
      q = '0; q.operation = OP_LEARN; q.dest_addr = {8'd20, 8'(i), 16'd0};
      q.dest_mask = 32'hFFFF_0000; q.sender_addr = 32'hC0A8_0002; q.recv_metric = 2;
      send_request(q, 0);
    end
    q = '0; q.operation = OP_ADVERT; send_request(q, 0);
    q.iface_select = 1; send_request(q, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: reg_write(REG_TIMEOUT, 32'd6);
        1: begin
          reg_write(REG_TIMEOUT, 32'd7);
          reg_write(REG_IFACE0_ADDR, 32'h0);
          reg_write(REG_IFACE0_MASK, 32'h0);
        end
        2: begin
          reg_write(REG_TIMEOUT, 32'd2);
          reg_write(REG_IFACE1_ADDR, 32'hFFFF_FFFF);
          reg_write(REG_IFACE1_MASK, 32'hFFFF_FFFF);
          reg_write(REG_IFACE0_ADDR, $urandom);
          reg_write(REG_IFACE0_MASK, 32'hFFFF_0000);
        end
        default: begin
          reg_write(REG_TIMEOUT, 32'd0);
          reg_write(REG_IFACE1_ADDR, 32'hC0A8_0101);
          reg_write(REG_IFACE1_MASK, 32'hFFFF_FE00);
        end
      endcase
      for (int i = 0; i < 65; i++) begin
        q = random_request();
        send_request(q, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS rip_route_table_engine_top");
    end else begin
      $display("FAIL rip_route_table_engine_top");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/rrte_pkg.sv
hdl/rrte_front.sv
hdl/rrte_cmd_queue.sv
hdl/rrte_back.sv
hdl/rip_route_table_engine_top.sv
bench/rrte_route_checker.sv
bench/rip_route_table_engine_top_test.sv
